// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro wraps one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define IKW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolation kernel weight check failed");

// Non-overlapping implication, checking the consequent in the cycle after the antecedent.
`define IKW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolation kernel weight check failed");

`endif

// ===== src/ikw_pkg.sv =====
// Package of the interpolation kernel weight block: widths, mode codes, lane control types,
// and the elaboration-time sinc series used to fill the Lanczos ROM. Depends on nothing.
package ikw_pkg;

    localparam int FRAC_BITS_DEF       = 13;
    localparam int LANCZOS_ENTRIES_DEF = 512;

    localparam int OFF_W    = 16;
    localparam int WEIGHT_W = 16;
    localparam int MODE_W   = 2;
    localparam int T_W      = 18;

    localparam int LANE_STAGES = 6;
    localparam int PIPE_DEPTH  = LANE_STAGES + 2;

    localparam logic [16:0] DIV3_MUL = 17'd43691;
    localparam int          DIV3_SH  = 17;
    localparam logic [31:0] PROD_RND = 32'd16384;

    localparam logic [63:0] Q28_ONE = 64'd1 << 28;
    localparam logic [63:0] Q15_ONE = 64'd32768;
    localparam logic [63:0] PI_Q28  = 64'd843314857;

    localparam logic [63:0] SINC_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [MODE_W-1:0] {
        MODE_BILINEAR = 2'd0,
        MODE_CUBIC    = 2'd1,
        MODE_LANCZOS  = 2'd2,
        MODE_BSPLINE  = 2'd3
    } kernel_mode_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
        kernel_mode_t           mode;
    } ikw_lane_ctrl_t;

    typedef struct packed {
        logic prod_en;
        logic out_en;
    } ikw_merge_ctrl_t;

    // Eleven-term power series of sin(w)/w with w in Q28, each term truncated.
    function automatic logic [63:0] sinc_q28(input logic [63:0] w);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        if (w == 64'd0)
        begin
            return Q28_ONE;
        end
        z    = (w * w + (64'd1 << 27)) >> 28;
        term = Q28_ONE;
        pos  = term;
        neg  = 64'd0;
        for (int k = 0; k < 10; k++)
        begin
            term = (term * z) / SINC_DIV[k];
            if (k[0] == 1'b0)
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        r = (pos > neg) ? pos - neg : 64'd0;
        if (r > Q28_ONE)
        begin
            r = Q28_ONE;
        end
        return r;
    endfunction

endpackage

// ===== src/ikw_in_if.sv =====
// Input channel of the interpolation kernel weight block: one item holds an x and y offset.
// Depends on ikw_pkg for the offset width.
interface ikw_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ikw_pkg::OFF_W-1:0]   x_offset;
    logic signed [ikw_pkg::OFF_W-1:0]   y_offset;

    modport source (output valid, output x_offset, output y_offset, input ready);
    modport sink   (input valid, input x_offset, input y_offset, output ready);
endinterface

// ===== src/ikw_out_if.sv =====
// Output channel of the interpolation kernel weight block: one item holds a Q1.15 weight.
// Depends on ikw_pkg for the weight width.
interface ikw_out_if;
    logic                           valid;
    logic                           ready;
    logic [ikw_pkg::WEIGHT_W-1:0]   weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

// ===== src/ikw_lane.sv =====
// One axis lane: magnitude, curve evaluation for all four kernel modes, Lanczos ROM lookup.
// Six register stages, advanced by the enables in the lane control struct. Depends on ikw_pkg.
module ikw_lane #(
    parameter int FRAC_BITS             = ikw_pkg::FRAC_BITS_DEF,
    parameter int LANCZOS_TABLE_ENTRIES = ikw_pkg::LANCZOS_ENTRIES_DEF
) (
    input  logic                                clk,
    input  ikw_pkg::ikw_lane_ctrl_t             ctrl,
    input  logic signed [ikw_pkg::OFF_W-1:0]    offset,
    output logic [ikw_pkg::WEIGHT_W-1:0]        weight
);
    import ikw_pkg::*;

    localparam int BW  = FRAC_BITS + 1;
    localparam int B2W = 2 * BW;
    localparam int B3W = 3 * BW;
    localparam int NW  = 3 * FRAC_BITS + 5;
    localparam int IW  = $clog2(LANCZOS_TABLE_ENTRIES);
    localparam int PW  = BW + IW + 1;

    localparam int BL_LSH = (FRAC_BITS + 1 < 15) ? 14 - FRAC_BITS : 0;
    localparam int BL_RSH = (FRAC_BITS + 1 > 15) ? FRAC_BITS - 14 : 0;
    localparam int LW     = FRAC_BITS + 3 + BL_LSH;
    localparam logic [LW-1:0] BL_RND = LW'((1 << BL_RSH) >> 1);

    localparam logic [BW:0]   TWO     = (BW + 1)'(1) << BW;
    localparam logic [NW-1:0] K4      = NW'(4) << (3 * FRAC_BITS);
    localparam logic [NW-1:0] CUB_RND = NW'(1) << (3 * FRAC_BITS - 14);
    localparam int            CUB_SH  = 3 * FRAC_BITS - 13;
    localparam logic [NW-1:0] BSP_RND = NW'(3) << (3 * FRAC_BITS - 15);
    localparam int            BSP_SH  = 3 * FRAC_BITS - 15;

    localparam logic [63:0] ENT64      = 64'(LANCZOS_TABLE_ENTRIES);
    localparam logic [63:0] HALF_ENT64 = 64'(LANCZOS_TABLE_ENTRIES / 2);
    localparam logic [63:0] TWO_ENT64  = 64'(2 * LANCZOS_TABLE_ENTRIES);

    typedef logic [WEIGHT_W-1:0] rom_t [LANCZOS_TABLE_ENTRIES];

    function automatic logic [WEIGHT_W-1:0] lanczos_entry(input logic [63:0] idx);
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] p;
        logic [63:0] q;
        w1 = (PI_Q28 * idx + HALF_ENT64) / ENT64;
        w2 = (PI_Q28 * idx + ENT64) / TWO_ENT64;
        p  = sinc_q28(w1) * sinc_q28(w2);
        q  = (p + (64'd1 << 40)) >> 41;
        if (q > Q15_ONE)
        begin
            q = Q15_ONE;
        end
        return WEIGHT_W'(q);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < LANCZOS_TABLE_ENTRIES; i++)
        begin
            r[i] = lanczos_entry(64'(i));
        end
        return r;
    endfunction

    localparam rom_t LANCZOS_ROM = build_rom();

    logic [OFF_W-1:0]    raw;
    logic [OFF_W-1:0]    mag;
    logic                zero;
    logic                hi;
    logic [BW-1:0]       a_b;
    logic [BW:0]         diff;
    logic [BW-1:0]       base;
    logic [WEIGHT_W-1:0] lin;
    logic [IW-1:0]       idx;

    logic                s1_zero_reg;
    logic                s1_hi_reg;
    kernel_mode_t        s1_mode_reg;
    logic [BW-1:0]       s1_base_reg;
    logic [WEIGHT_W-1:0] s1_lin_reg;
    logic [WEIGHT_W-1:0] s1_rom_reg;

    logic                s2_zero_reg;
    logic                s2_hi_reg;
    kernel_mode_t        s2_mode_reg;
    logic [BW-1:0]       s2_base_reg;
    logic [B2W-1:0]      s2_sq_reg;
    logic [WEIGHT_W-1:0] s2_simple_reg;

    logic                s3_zero_reg;
    logic                s3_hi_reg;
    kernel_mode_t        s3_mode_reg;
    logic [B2W-1:0]      s3_sq_reg;
    logic [B3W-1:0]      s3_cube_reg;
    logic [WEIGHT_W-1:0] s3_simple_reg;

    logic [NW-1:0]       num_next;
    logic                s4_zero_reg;
    kernel_mode_t        s4_mode_reg;
    logic [NW-1:0]       s4_num_reg;
    logic [WEIGHT_W-1:0] s4_simple_reg;

    logic [T_W-1:0]      t_next;
    logic                s5_zero_reg;
    kernel_mode_t        s5_mode_reg;
    logic [T_W-1:0]      s5_t_reg;
    logic [WEIGHT_W-1:0] s5_simple_reg;

    logic [T_W-2:0]      half;
    logic [2*T_W-3:0]    div_prod;
    logic [WEIGHT_W-1:0] quo;
    logic [WEIGHT_W-1:0] weight_next;
    logic [WEIGHT_W-1:0] s6_weight_reg;

    assign raw  = offset;
    assign mag  = raw[OFF_W-1] ? (~raw) + OFF_W'(1) : raw;
    assign zero = |(mag >> BW);
    assign hi   = |(mag >> FRAC_BITS);
    assign a_b  = BW'(mag);
    assign diff = TWO - (BW + 1)'(mag);
    assign base = (ctrl.mode == MODE_BSPLINE && hi) ? diff[BW-1:0] : a_b;
    assign lin  = WEIGHT_W'(((LW'(diff) << BL_LSH) + BL_RND) >> BL_RSH);
    assign idx  = zero ? '0 : IW'((PW'(a_b) * PW'(LANCZOS_TABLE_ENTRIES)) >> BW);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_zero_reg <= zero;
            s1_hi_reg   <= hi;
            s1_mode_reg <= ctrl.mode;
            s1_base_reg <= base;
            s1_lin_reg  <= lin;
            s1_rom_reg  <= LANCZOS_ROM[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            s2_zero_reg   <= s1_zero_reg;
            s2_hi_reg     <= s1_hi_reg;
            s2_mode_reg   <= s1_mode_reg;
            s2_base_reg   <= s1_base_reg;
            s2_sq_reg     <= B2W'(s1_base_reg) * B2W'(s1_base_reg);
            s2_simple_reg <= (s1_mode_reg == MODE_BILINEAR) ? s1_lin_reg : s1_rom_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            s3_zero_reg   <= s2_zero_reg;
            s3_hi_reg     <= s2_hi_reg;
            s3_mode_reg   <= s2_mode_reg;
            s3_sq_reg     <= s2_sq_reg;
            s3_cube_reg   <= B3W'(s2_sq_reg) * B3W'(s2_base_reg);
            s3_simple_reg <= s2_simple_reg;
        end
    end

    always_comb
    begin
        case (s3_mode_reg)
            MODE_CUBIC:
            begin
                num_next = NW'(s3_cube_reg) + K4
                           - ((NW'(s3_sq_reg) + (NW'(s3_sq_reg) << 1)) << FRAC_BITS);
            end
            MODE_BSPLINE:
            begin
                if (s3_hi_reg)
                begin
                    num_next = NW'(s3_cube_reg);
                end
                else
                begin
                    num_next = NW'(s3_cube_reg) + (NW'(s3_cube_reg) << 1) + K4
                               - (((NW'(s3_sq_reg) << 1) + (NW'(s3_sq_reg) << 2)) << FRAC_BITS);
                end
            end
            default:
            begin
                num_next = NW'(s3_cube_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            s4_zero_reg   <= s3_zero_reg;
            s4_mode_reg   <= s3_mode_reg;
            s4_num_reg    <= num_next;
            s4_simple_reg <= s3_simple_reg;
        end
    end

    assign t_next = (s4_mode_reg == MODE_CUBIC) ? T_W'((s4_num_reg + CUB_RND) >> CUB_SH)
                                                : T_W'((s4_num_reg + BSP_RND) >> BSP_SH);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            s5_zero_reg   <= s4_zero_reg;
            s5_mode_reg   <= s4_mode_reg;
            s5_t_reg      <= t_next;
            s5_simple_reg <= s4_simple_reg;
        end
    end

    // The B-spline value is the rounded sum halved and then divided by three.
    assign half     = s5_t_reg[T_W-1:1];
    assign div_prod = half * DIV3_MUL;
    assign quo      = WEIGHT_W'(div_prod >> DIV3_SH);

    always_comb
    begin
        if (s5_zero_reg)
        begin
            weight_next = '0;
        end
        else
        begin
            case (s5_mode_reg)
                MODE_BILINEAR: weight_next = s5_simple_reg;
                MODE_LANCZOS:  weight_next = s5_simple_reg;
                MODE_CUBIC:    weight_next = WEIGHT_W'(s5_t_reg);
                MODE_BSPLINE:  weight_next = quo;
                default:       weight_next = s5_simple_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[5])
        begin
            s6_weight_reg <= weight_next;
        end
    end

    assign weight = s6_weight_reg;

endmodule

// ===== src/ikw_merge.sv =====
// Merging stage: multiplies the two axis weights and rounds the product back to Q1.15.
// Two register stages, the second one being the output register. Depends on ikw_pkg.
module ikw_merge (
    input  logic                            clk,
    input  ikw_pkg::ikw_merge_ctrl_t        ctrl,
    input  logic [ikw_pkg::WEIGHT_W-1:0]    wx,
    input  logic [ikw_pkg::WEIGHT_W-1:0]    wy,
    output logic [ikw_pkg::WEIGHT_W-1:0]    weight
);
    import ikw_pkg::*;

    logic [2*WEIGHT_W-1:0] prod_reg;
    logic [WEIGHT_W-1:0]   weight_next;
    logic [WEIGHT_W-1:0]   weight_reg;

    assign weight_next = WEIGHT_W'((prod_reg + PROD_RND) >> 15);

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_reg <= (2 * WEIGHT_W)'(wx) * (2 * WEIGHT_W)'(wy);
        end
        if (ctrl.out_en)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

// ===== src/interpolation_kernel_weight.sv =====
// Top level of the separable interpolation kernel weight block: mode register, stage valids,
// two axis lanes and the merging stage. Depends on ikw_pkg, ikw_in_if, ikw_out_if, ikw_lane, ikw_merge.
//
//   Channel      Direction   Item contents
//   in_ch        sink        x_offset, y_offset (signed Q3.13)
//   out_ch       source      weight (unsigned Q1.15)
//   cfg_write_*  input       kernel_mode, written when cfg_write_en is high
//
// One item is accepted per cycle while the pipeline has room; its result goes through six lane stages
// (magnitude and ROM read, square, cube, numerator, rounding, divide by three) and two merge stages.
// Reset clears the stage valid bits and sets kernel_mode to bilinear; the ROM is constant.
// A stall at the output holds the output register while earlier stages close up their bubbles,
// so in_ch.ready falls only when all eight stages hold an item.
module interpolation_kernel_weight #(
    parameter int FRAC_BITS             = ikw_pkg::FRAC_BITS_DEF,
    parameter int LANCZOS_TABLE_ENTRIES = ikw_pkg::LANCZOS_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [ikw_pkg::MODE_W-1:0]  cfg_write_data,
    ikw_in_if.sink                      in_ch,
    ikw_out_if.source                   out_ch
);
    import ikw_pkg::*;

    kernel_mode_t            kernel_mode_reg;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   valid_next;
    logic [PIPE_DEPTH-1:0]   en;
    ikw_lane_ctrl_t          lane_ctrl;
    ikw_merge_ctrl_t         merge_ctrl;
    logic [WEIGHT_W-1:0]     wx;
    logic [WEIGHT_W-1:0]     wy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg <= MODE_BILINEAR;
        end
        else if (cfg_write_en)
        begin
            kernel_mode_reg <= kernel_mode_t'(cfg_write_data);
        end
    end

    always_comb
    begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || out_ch.ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_ch.valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign lane_ctrl.en        = en[LANE_STAGES-1:0];
    assign lane_ctrl.mode      = kernel_mode_reg;
    assign merge_ctrl.prod_en  = en[LANE_STAGES];
    assign merge_ctrl.out_en   = en[LANE_STAGES+1];

    ikw_lane #(
        .FRAC_BITS             (FRAC_BITS),
        .LANCZOS_TABLE_ENTRIES (LANCZOS_TABLE_ENTRIES)
    ) u_lane_x (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .offset (in_ch.x_offset),
        .weight (wx)
    );

    ikw_lane #(
        .FRAC_BITS             (FRAC_BITS),
        .LANCZOS_TABLE_ENTRIES (LANCZOS_TABLE_ENTRIES)
    ) u_lane_y (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .offset (in_ch.y_offset),
        .weight (wy)
    );

    ikw_merge u_merge (
        .clk    (clk),
        .ctrl   (merge_ctrl),
        .wx     (wx),
        .wy     (wy),
        .weight (out_ch.weight)
    );

    assign in_ch.ready  = en[0];
    assign out_ch.valid = valid_reg[PIPE_DEPTH-1];

endmodule

// ===== src/ikw_checker.sv =====
// Port-level checker for the interpolation kernel weight block, bound to the top level.
// Depends on ikw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ikw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ikw_pkg::WEIGHT_W-1:0] out_weight
);
    import ikw_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign inflight_next = inflight_reg + CNT_W'(in_valid && in_ready)
                           - CNT_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `IKW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_weight))
    `IKW_ASSERT_IMPL(a_empty_ready, clk, rst_n, inflight_reg == '0, in_ready)
    `IKW_ASSERT_IMPL(a_out_has_item, clk, rst_n, out_valid, inflight_reg != '0)
    `IKW_ASSERT_IMPL(a_full_stall, clk, rst_n, inflight_reg == CNT_W'(PIPE_DEPTH) && !out_ready, !in_ready)

endmodule

bind interpolation_kernel_weight ikw_checker u_ikw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_weight (out_ch.weight)
);
